FILE: rtl/q2e_pkg.sv
// shared constants, types and the cordic angle table for the quaternion to euler block
package q2e_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int CW = 40;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic        [31:0]   z;
        logic                 zero;
    } t_cvec;

    function automatic logic [31:0] atan_const(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0: r = 32'd536870912;
            5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;
            5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;
            5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;
            5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;
            5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] round_angle(input logic [31:0] z);
        logic [31:0] t;
        t = z + 32'h0000_8000;
        return t[31:16];
    endfunction
endpackage

FILE: rtl/quaternion_to_euler_zyx.sv
// quaternion to zyx euler angles: products, square root and three cordic pipelines
// path from input item to output register: product stages, square root, cordic stages, output register
// throughput: one item per cycle; the whole pipeline advances when the output may move
// roll and yaw ride delay lines alongside the square root to meet pitch
// reset clears the valid bits only; data registers are not reset
module quaternion_to_euler_zyx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_scalar, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // roll_angle, pitch_angle, yaw_angle
);
    localparam int SQ = 32;
    localparam int LAT = 2 + SQ + q2e_pkg::NSTG + 1;

    logic               w_en;
    logic [LAT-1:0]     r_vld;
    logic signed [33:0] w_c23, w_c33, w_c12, w_c11;
    logic signed [31:0] w_c13, w_c13d;
    logic [30:0]        w_root;
    logic signed [33:0] r_d23 [0:SQ-1];
    logic signed [33:0] r_d33 [0:SQ-1];
    logic signed [33:0] r_d12 [0:SQ-1];
    logic signed [33:0] r_d11 [0:SQ-1];
    logic [31:0]        w_zr, w_zp, w_zy;
    logic signed [31:0] w_zs;
    logic signed [16:0] w_p;
    logic [47:0]        r_out;
    logic               r_ov;

    assign w_en = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
            r_ov  <= r_vld[LAT-1];
        end
    end

    q2e_dcm u_dcm (
        .i_clk(i_clk), .i_en(w_en),
        .i_qs(s_axis_tdata[15:0]), .i_qx(s_axis_tdata[31:16]),
        .i_qy(s_axis_tdata[47:32]), .i_qz(s_axis_tdata[63:48]),
        .o_c23(w_c23), .o_c33(w_c33), .o_c13(w_c13), .o_c12(w_c12), .o_c11(w_c11)
    );

    q2e_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(w_en), .i_c13(w_c13), .o_c13(w_c13d), .o_root(w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d23[0] <= w_c23;
            r_d33[0] <= w_c33;
            r_d12[0] <= w_c12;
            r_d11[0] <= w_c11;
            for (int k = 1; k < SQ; k++) begin
                r_d23[k] <= r_d23[k-1];
                r_d33[k] <= r_d33[k-1];
                r_d12[k] <= r_d12[k-1];
                r_d11[k] <= r_d11[k-1];
            end
        end
    end

    q2e_cordic u_roll (
        .i_clk(i_clk), .i_en(w_en),
        .i_x(q2e_pkg::CW'(r_d33[SQ-1])), .i_y(q2e_pkg::CW'(r_d23[SQ-1])), .o_z(w_zr)
    );
    q2e_cordic u_pitch (
        .i_clk(i_clk), .i_en(w_en),
        .i_x(q2e_pkg::CW'({1'b0, w_root})), .i_y(q2e_pkg::CW'(w_c13d)), .o_z(w_zp)
    );
    q2e_cordic u_yaw (
        .i_clk(i_clk), .i_en(w_en),
        .i_x(q2e_pkg::CW'(r_d11[SQ-1])), .i_y(q2e_pkg::CW'(r_d12[SQ-1])), .o_z(w_zy)
    );

    always_comb begin
        w_zs = $signed(w_zp + 32'h0000_8000);
        w_p  = -17'(w_zs >>> 16);
        if (w_p > 17'sd16384) begin
            w_p = 17'sd16384;
        end else if (w_p < -17'sd16384) begin
            w_p = -17'sd16384;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= {q2e_pkg::round_angle(w_zy), w_p[15:0], q2e_pkg::round_angle(w_zr)};
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_out))
        else $error("output item changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> ($signed(r_out[31:16]) <= 16'sd16384 && $signed(r_out[31:16]) >= -16'sd16384))
        else $error("pitch out of range");
endmodule

FILE: rtl/q2e_dcm.sv
// direction-cosine terms from quaternion products, two register stages
module q2e_dcm (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_qs,
    input  logic signed [15:0]  i_qx,
    input  logic signed [15:0]  i_qy,
    input  logic signed [15:0]  i_qz,
    output logic signed [33:0]  o_c23,
    output logic signed [33:0]  o_c33,
    output logic signed [31:0]  o_c13,
    output logic signed [33:0]  o_c12,
    output logic signed [33:0]  o_c11
);
    logic signed [31:0] r_ss, r_xx, r_yy, r_zz, r_yz, r_xs, r_xz, r_ys, r_xy, r_zs;
    logic signed [33:0] n_c13;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ss <= i_qs * i_qs;
            r_xx <= i_qx * i_qx;
            r_yy <= i_qy * i_qy;
            r_zz <= i_qz * i_qz;
            r_yz <= i_qy * i_qz;
            r_xs <= i_qx * i_qs;
            r_xz <= i_qx * i_qz;
            r_ys <= i_qy * i_qs;
            r_xy <= i_qx * i_qy;
            r_zs <= i_qz * i_qs;
        end
    end

    assign n_c13 = (34'(r_xz) - 34'(r_ys)) <<< 1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_c23 <= (34'(r_yz) + 34'(r_xs)) <<< 1;
            o_c33 <= 34'(r_ss) - 34'(r_xx) - 34'(r_yy) + 34'(r_zz);
            o_c12 <= (34'(r_xy) + 34'(r_zs)) <<< 1;
            o_c11 <= 34'(r_ss) + 34'(r_xx) - 34'(r_yy) - 34'(r_zz);
            if (n_c13 >= 34'(q2e_pkg::ONE_Q30)) begin
                o_c13 <= q2e_pkg::ONE_Q30;
            end else if (n_c13 <= -34'(q2e_pkg::ONE_Q30)) begin
                o_c13 <= -q2e_pkg::ONE_Q30;
            end else begin
                o_c13 <= n_c13[31:0];
            end
        end
    end
endmodule

FILE: rtl/q2e_sqrt.sv
// pipelined integer square root of 2^60 - c13^2, one result bit a stage
module q2e_sqrt (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_c13,
    output logic signed [31:0] o_c13,
    output logic        [30:0] o_root
);
    localparam int NB = 31;
    logic        [61:0] r_rad  [1:NB];
    logic        [30:0] r_res  [1:NB];
    logic signed [31:0] r_c13  [1:NB];
    logic        [61:0] r_sq;
    logic signed [31:0] r_c0;
    logic signed [63:0] w_sq;
    logic        [61:0] w_rad0;

    assign w_sq = i_c13 * i_c13;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= w_sq[61:0];
            r_c0 <= i_c13;
        end
    end

    assign w_rad0 = 62'(64'h1000_0000_0000_0000 - {2'b00, r_sq});

    genvar g;
    generate
        for (g = 0; g < NB; g++) begin : g_bit
            localparam int B = NB - 1 - g;
            logic        [61:0] w_rad;
            logic        [30:0] w_res;
            logic signed [31:0] w_c;
            logic        [61:0] w_trial;
            logic        [61:0] w_rem;
            if (g == 0) begin : g_head
                assign w_rad = w_rad0;
                assign w_res = '0;
                assign w_c   = r_c0;
            end else begin : g_tail
                assign w_rad = r_rad[g];
                assign w_res = r_res[g];
                assign w_c   = r_c13[g];
            end
            assign w_trial = ({31'd0, w_res} << (B + 1)) | (62'd1 << (2 * B));
            assign w_rem = w_rad - w_trial;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c13[g+1] <= w_c;
                    if (w_rad >= w_trial) begin
                        r_rad[g+1] <= w_rem;
                        r_res[g+1] <= w_res | (31'd1 << B);
                    end else begin
                        r_rad[g+1] <= w_rad;
                        r_res[g+1] <= w_res;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_res[NB];
    assign o_c13  = r_c13[NB];
endmodule

FILE: rtl/q2e_cordic.sv
// unrolled cordic vectoring unit, one register stage per iteration
module q2e_cordic (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [q2e_pkg::CW-1:0] i_x,
    input  logic signed [q2e_pkg::CW-1:0] i_y,
    output logic        [31:0]            o_z
);
    localparam int N = q2e_pkg::NSTG;
    q2e_pkg::t_cvec r_s [0:N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0].zero <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_s[0].x <= -i_x;
                r_s[0].y <= -i_y;
                r_s[0].z <= q2e_pkg::HALF_TURN;
            end else begin
                r_s[0].x <= i_x;
                r_s[0].y <= i_y;
                r_s[0].z <= '0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stg
            logic [31:0] w_a;
            assign w_a = q2e_pkg::atan_const(5'(g));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_s[g+1].zero <= r_s[g].zero;
                    if (r_s[g].y >= 0) begin
                        r_s[g+1].x <= r_s[g].x + (r_s[g].y >>> g);
                        r_s[g+1].y <= r_s[g].y - (r_s[g].x >>> g);
                        r_s[g+1].z <= r_s[g].z + w_a;
                    end else begin
                        r_s[g+1].x <= r_s[g].x - (r_s[g].y >>> g);
                        r_s[g+1].y <= r_s[g].y + (r_s[g].x >>> g);
                        r_s[g+1].z <= r_s[g].z - w_a;
                    end
                end
            end
        end
    endgenerate

    assign o_z = r_s[N].zero ? 32'd0 : r_s[N].z;
endmodule
